/* hw/rtl/integer_to_ascii_formatter_macros.svh */
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

`ifndef SYNTHESIS
// expr must hold at every clock edge out of reset
`define ITAF_ASSERT_HOLD(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// pre at one edge implies post at the next
`define ITAF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define ITAF_ASSERT_HOLD(lbl, expr, msg)
`define ITAF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* hw/rtl/itaf_pkg.sv */
// Package for the integer to ASCII formatter: sizes, codes, types, helpers.
`default_nettype none
package itaf_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int DIGIT_SLOTS = 11;
	localparam int DIGIT_W     = 4;
	localparam int SLOT_W      = $clog2(DIGIT_SLOTS);
	localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);
	localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
	localparam int WIDTH_W     = 6;
	localparam int PREC_W      = 7;
	localparam int CHAR_W      = 8;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

	localparam logic [DIGIT_W-1:0] DEC_RADIX = 4'd10;

	typedef logic [DIGIT_W-1:0] digit_t;

	typedef struct packed {
		logic       start;
		logic [1:0] base_sel;
	} conv_ctrl_t;

	typedef struct packed {
		logic               done;
		logic [COUNT_W-1:0] count;
	} conv_stat_t;

	typedef struct packed {
		logic               upper;
		logic               negative;
		logic [WIDTH_W-1:0] min_width;
		logic               zero_pad;
		logic [PREC_W-1:0]  precision;
	} fmt_t;

	function automatic logic [CHAR_W-1:0] digit_char(digit_t d, logic up);
		logic [CHAR_W-1:0] base_ch;
		logic [CHAR_W-1:0] ofs;
		if (d < DEC_RADIX) begin
			base_ch = CH_ZERO;
			ofs = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		end else begin
			base_ch = up ? CH_UPPER_A : CH_LOWER_A;
			ofs = {{(CHAR_W-DIGIT_W){1'b0}}, d - DEC_RADIX};
		end
		return base_ch + ofs;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/itaf_num_if.sv */
// Input channel: one number with its format fields per item.
`default_nettype none
interface itaf_num_if;
	import itaf_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [1:0]            base_sel;
	logic                  upper;
	logic                  negative;
	logic [WIDTH_W-1:0]    min_width;
	logic                  zero_pad;
	logic signed [PREC_W-1:0] precision;

	modport source (
		output valid, value, base_sel, upper, negative, min_width, zero_pad, precision,
		input  ready
	);
	modport sink (
		input  valid, value, base_sel, upper, negative, min_width, zero_pad, precision,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/itaf_text_if.sv */
// Output channel: one ASCII character per item.
`default_nettype none
interface itaf_text_if;
	import itaf_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              char_valid;
	logic              last;

	modport source (
		output valid, out_char, char_valid, last,
		input  ready
	);
	modport sink (
		input  valid, out_char, char_valid, last,
		output ready
	);
endinterface
`default_nettype wire

/* hw/rtl/itaf_conv.sv */
// Bit-serial radix converter: shifts the value into a digit chain, then counts digits.
`default_nettype none
module itaf_conv (
	input  logic                            clk,
	input  logic                            arst_n,
	input  itaf_pkg::conv_ctrl_t            ctrl,
	input  logic [itaf_pkg::VALUE_BITS-1:0] value,
	input  logic [itaf_pkg::SLOT_W-1:0]     rd_idx,
	output itaf_pkg::digit_t                rd_digit,
	output itaf_pkg::conv_stat_t            stat
);
	import itaf_pkg::*;

	logic [VALUE_BITS-1:0] shift_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic                  run_q;
	logic                  scan_q;
	logic                  done_q;
	logic [1:0]            base_q;
	logic [COUNT_W-1:0]    count_q;
	logic [COUNT_W-1:0]    count_c;
	digit_t                digit_q [DIGIT_SLOTS];
	digit_t                digit_c [DIGIT_SLOTS];
	digit_t                adj_c   [DIGIT_SLOTS];
	logic [DIGIT_SLOTS:0]  carry_c;

	// one step per cycle: decimal slots get the add-3 correction first
	always_comb begin
		carry_c[0] = shift_q[VALUE_BITS-1];
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			adj_c[i] = (base_q == BASE_DEC && digit_q[i] >= DIGIT_W'(5)) ?
				digit_q[i] + DIGIT_W'(3) : digit_q[i];
			if (base_q == BASE_OCT) begin
				digit_c[i]   = {1'b0, adj_c[i][1:0], carry_c[i]};
				carry_c[i+1] = adj_c[i][2];
			end else begin
				digit_c[i]   = {adj_c[i][2:0], carry_c[i]};
				carry_c[i+1] = adj_c[i][3];
			end
		end
	end

	always_comb begin
		count_c = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (digit_q[i] != '0) begin
				count_c = COUNT_W'(i + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			scan_q    <= 1'b0;
			done_q    <= 1'b0;
			bit_cnt_q <= '0;
			count_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				run_q     <= 1'b1;
				bit_cnt_q <= '0;
			end else if (run_q) begin
				bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
				if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
					run_q  <= 1'b0;
					scan_q <= 1'b1;
				end
			end else if (scan_q) begin
				scan_q  <= 1'b0;
				done_q  <= 1'b1;
				count_q <= count_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			shift_q <= value;
			base_q  <= ctrl.base_sel;
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				digit_q[i] <= '0;
			end
		end else if (run_q) begin
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				digit_q[i] <= digit_c[i];
			end
		end
	end

	assign rd_digit   = digit_q[rd_idx];
	assign stat.done  = done_q;
	assign stat.count = count_q;

endmodule
`default_nettype wire

/* hw/rtl/itaf_emit.sv */
// Field sequencer: sizes sign, pad, zeros, digits; one char per cycle unless stalled.
`default_nettype none
module itaf_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  itaf_pkg::fmt_t              fmt,
	input  itaf_pkg::conv_stat_t        stat,
	output logic [itaf_pkg::SLOT_W-1:0] rd_idx,
	input  itaf_pkg::digit_t            rd_digit,
	itaf_text_if.source                 text
);
	import itaf_pkg::*;

	localparam int NEED_SIGN_A = 0;
	localparam int NEED_PAD    = 1;
	localparam int NEED_SIGN_B = 2;
	localparam int NEED_ZERO   = 3;
	localparam int NEED_DIGIT  = 4;
	localparam int NEED_W      = 5;

	// sizing
	logic                prec_neg;
	logic [WIDTH_W-1:0]  prec6;
	logic [COUNT_W-1:0]  n_c;
	logic [WIDTH_W-1:0]  n6;
	logic                prec_gt;
	logic [WIDTH_W-1:0]  digits_c;
	logic [WIDTH_W:0]    len_c;
	logic [WIDTH_W-1:0]  pad_c;
	logic [WIDTH_W-1:0]  zeros_c;
	logic                zp_c;
	logic [NEED_W-1:0]   need_c;

	// sequencing
	logic [NEED_W-1:0]   need_q, need_n;
	logic [WIDTH_W-1:0]  pad_q, pad_n;
	logic [WIDTH_W-1:0]  zeros_q, zeros_n;
	logic [COUNT_W-1:0]  dig_q, dig_n;
	logic                empty_q;
	logic                upper_q;
	logic                zp_q;
	logic                out_v_q;
	logic [CHAR_W-1:0]   char_q, char_c;
	logic                cv_q, cv_c;
	logic                last_q;
	logic                adv;
	logic                fire;

	always_comb begin
		prec_neg = fmt.precision[PREC_W-1];
		prec6    = fmt.precision[PREC_W-2:0];
		// zero value with a nonzero precision still shows one digit
		n_c      = (stat.count == '0 && fmt.precision != '0) ? COUNT_W'(1) : stat.count;
		n6       = {{(WIDTH_W-COUNT_W){1'b0}}, n_c};
		prec_gt  = !prec_neg && (prec6 > n6);
		digits_c = prec_gt ? prec6 : n6;
		len_c    = {1'b0, digits_c} + {{WIDTH_W{1'b0}}, fmt.negative};
		pad_c    = ({1'b0, fmt.min_width} > len_c) ?
			fmt.min_width - len_c[WIDTH_W-1:0] : '0;
		zeros_c  = prec_gt ? prec6 - n6 : '0;
		zp_c     = fmt.zero_pad && prec_neg;
		need_c[NEED_SIGN_A] = fmt.negative && zp_c;
		need_c[NEED_PAD]    = pad_c != '0;
		need_c[NEED_SIGN_B] = fmt.negative && !zp_c;
		need_c[NEED_ZERO]   = zeros_c != '0;
		need_c[NEED_DIGIT]  = n_c != '0;
	end

	assign rd_idx = SLOT_W'(dig_q - COUNT_W'(1));

	always_comb begin
		need_n  = need_q;
		pad_n   = pad_q;
		zeros_n = zeros_q;
		dig_n   = dig_q;
		char_c  = CH_NUL;
		cv_c    = 1'b1;
		if (need_q[NEED_SIGN_A]) begin
			char_c = CH_MINUS;
			need_n[NEED_SIGN_A] = 1'b0;
		end else if (need_q[NEED_PAD]) begin
			char_c = zp_q ? CH_ZERO : CH_SPACE;
			pad_n  = pad_q - WIDTH_W'(1);
			if (pad_q == WIDTH_W'(1)) begin
				need_n[NEED_PAD] = 1'b0;
			end
		end else if (need_q[NEED_SIGN_B]) begin
			char_c = CH_MINUS;
			need_n[NEED_SIGN_B] = 1'b0;
		end else if (need_q[NEED_ZERO]) begin
			char_c  = CH_ZERO;
			zeros_n = zeros_q - WIDTH_W'(1);
			if (zeros_q == WIDTH_W'(1)) begin
				need_n[NEED_ZERO] = 1'b0;
			end
		end else if (need_q[NEED_DIGIT]) begin
			char_c = digit_char(rd_digit, upper_q);
			dig_n  = dig_q - COUNT_W'(1);
			if (dig_q == COUNT_W'(1)) begin
				need_n[NEED_DIGIT] = 1'b0;
			end
		end else begin
			// empty field
			cv_c = 1'b0;
		end
	end

	assign adv  = !out_v_q || text.ready;
	assign fire = adv && (need_q != '0 || empty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			need_q  <= '0;
			empty_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (stat.done) begin
				need_q  <= need_c;
				empty_q <= need_c == '0;
			end else if (fire) begin
				need_q  <= need_n;
				empty_q <= 1'b0;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (adv) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			pad_q   <= pad_c;
			zeros_q <= zeros_c;
			dig_q   <= n_c;
			upper_q <= fmt.upper;
			zp_q    <= zp_c;
		end else if (fire) begin
			pad_q   <= pad_n;
			zeros_q <= zeros_n;
			dig_q   <= dig_n;
		end
		if (fire) begin
			char_q <= char_c;
			cv_q   <= cv_c;
			last_q <= need_n == '0;
		end
	end

	assign text.valid      = out_v_q;
	assign text.out_char   = char_q;
	assign text.char_valid = cv_q;
	assign text.last       = last_q;

endmodule
`default_nettype wire

/* hw/rtl/integer_to_ascii_formatter.sv */
// Top level of the integer to ASCII formatter.
//
// Channel num takes one item: a 32-bit magnitude, sign flag, radix select,
// letter case, minimum width, zero-pad flag and precision (-1 = none).
// Channel text returns the printf-style field, one character per item, most
// significant first, with last set on the final one. An empty field gives
// one item with char_valid low and last high.
// After the input item is accepted, the bit-serial conversion shifts one
// bit of the value per cycle through the digit chain; a scan step then
// counts the digits, and the sequencer sizes the field and registers the
// first character in the output register. Characters then leave at one per
// cycle while the receiver is ready. One item is in work at a time: num.ready
// is low from accept until the last character has been taken.
// A stalled receiver holds the current character in the output register
// and the sequencer waits; nothing is dropped.
// Reset clears the control state; the block comes up ready and idle.
`default_nettype none
`include "integer_to_ascii_formatter_macros.svh"
module integer_to_ascii_formatter (
	input  logic        clk,
	input  logic        arst_n,
	itaf_num_if.sink    num,
	itaf_text_if.source text
);
	import itaf_pkg::*;

	logic                 busy_q;
	logic                 accept;
	fmt_t                 fmt_q;
	conv_ctrl_t           conv_ctrl;
	conv_stat_t           conv_stat;
	logic [SLOT_W-1:0]    rd_idx;
	digit_t               rd_digit;

	assign num.ready = !busy_q;
	assign accept    = num.valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (text.valid && text.ready && text.last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fmt_q.upper     <= num.upper;
			fmt_q.negative  <= num.negative;
			fmt_q.min_width <= num.min_width;
			fmt_q.zero_pad  <= num.zero_pad;
			fmt_q.precision <= num.precision;
		end
	end

	assign conv_ctrl.start    = accept;
	assign conv_ctrl.base_sel = num.base_sel;

	itaf_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (conv_ctrl),
		.value    (num.value),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.stat     (conv_stat)
	);

	itaf_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.fmt      (fmt_q),
		.stat     (conv_stat),
		.rd_idx   (rd_idx),
		.rd_digit (rd_digit),
		.text     (text)
	);

	`ITAF_ASSERT_HOLD(a_no_out_when_ready, !(text.valid && num.ready), "output valid while idle")
	`ITAF_ASSERT_NEXT(a_busy_after_accept, num.valid && num.ready, !num.ready, "ready after accept")
	`ITAF_ASSERT_NEXT(a_ready_after_last, text.valid && text.ready && text.last, num.ready, "not ready after last")
	`ITAF_ASSERT_HOLD(a_empty_is_last, !(text.valid && !text.char_valid) || text.last, "empty item not last")

endmodule
`default_nettype wire
